[src/gakf_pkg.sv]
package gakf_pkg;

  localparam int FracBitsDefault = 16;
  localparam int DataWidth = 32;
  localparam int NoiseWidth = 31;
  localparam int ElapsedWidth = 16;

  localparam logic [NoiseWidth-1:0] AngleNoiseReset   = 31'd66;
  localparam logic [NoiseWidth-1:0] BiasNoiseReset    = 31'd197;
  localparam logic [NoiseWidth-1:0] MeasureNoiseReset = 31'd19661;

  localparam logic [1:0] RegAngleNoise   = 2'd0;
  localparam logic [1:0] RegBiasNoise    = 2'd1;
  localparam logic [1:0] RegMeasureNoise = 2'd2;

  // Datapath micro-operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RB,
    OP_ANG,
    OP_T,
    OP_SUMC,
    OP_EC,
    OP_P00A,
    OP_ET,
    OP_P00B,
    OP_PRED,
    OP_S,
    OP_DIVSTART,
    OP_K0,
    OP_K1,
    OP_M0,
    OP_M1,
    OP_M2,
    OP_M3,
    OP_M4,
    OP_M5,
    OP_COMMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       div_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic s_zero;
  } dp_sts_t;

  function automatic logic signed [31:0] clamp64(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] s;
    s = 64'(a) + 64'(b);
    return clamp64(s);
  endfunction

  function automatic logic signed [31:0] ssub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] s;
    s = 64'(a) - 64'(b);
    return clamp64(s);
  endfunction

endpackage

[src/gakf_divider.sv]
// Restoring signed divider: quotient of (n << frac) / d, truncated toward zero,
// saturated to 32 bits. One quotient bit per cycle.
module gakf_divider import gakf_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] dividend;
  logic [NW-1:0] qbits;
  logic [32:0]   rem;
  logic [31:0]   dmag;
  logic          neg;
  logic [CW-1:0] count;
  logic          busy;

  logic [33:0] trial;
  logic [32:0] rem_shift;
  logic [NW-1:0] nmag;
  logic signed [NW:0] sq;

  // Magnitude of the shifted numerator.
  always_comb begin
    logic signed [NW-1:0] nx;
    nx = NW'(num) <<< FRAC_BITS;
    nmag = nx[NW-1] ? NW'(-nx) : nx;
  end

  assign rem_shift = {rem[31:0], dividend[NW-1]};
  assign trial = {1'b0, rem_shift} - {2'b00, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CW'(NW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= nmag;
      dmag <= den[31] ? 32'(-den) : 32'(den);
      neg <= num[31] ^ den[31];
      rem <= '0;
      qbits <= '0;
    end else if (busy) begin
      dividend <= dividend << 1;
      if (!trial[33]) begin
        rem <= trial[32:0];
        qbits <= {qbits[NW-2:0], 1'b1};
      end else begin
        rem <= rem_shift;
        qbits <= {qbits[NW-2:0], 1'b0};
      end
    end
  end

  // Sign and saturation of the finished quotient.
  always_comb begin
    sq = neg ? -$signed({1'b0, qbits}) : $signed({1'b0, qbits});
    quo = clamp64(64'(sq));
  end

endmodule

[src/gakf_datapath.sv]
// Filter datapath: state, scratch registers, one multiplier and the divider.
module gakf_datapath import gakf_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic signed [31:0] rate_sample,
  input  logic signed [31:0] angle_sample,
  input  logic [15:0]        elapsed,
  input  logic [30:0]        angle_noise,
  input  logic [30:0]        bias_noise,
  input  logic [30:0]        measure_noise,
  output logic signed [31:0] angle_estimate,
  output logic signed [31:0] bias_estimate
);

  logic signed [31:0] angle_reg, bias_reg, cov_aa, cov_ab, cov_ba, cov_bb;
  logic signed [31:0] rate_q, meas_q;
  logic [15:0]        e_q;
  logic signed [31:0] t_q, acc, p00, ps, k0, k1, y;
  logic signed [31:0] na_aa, na_ab, na_ba, na_bb;
  logic signed [31:0] mul_a, mul_b, mul_r;
  logic signed [63:0] prod;
  logic               div_done;
  logic signed [31:0] div_q;

  // Shared multiplier: operands picked by the current operation.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_ANG:  begin mul_a = $signed({16'd0, e_q}); mul_b = acc;    end
      OP_T:    begin mul_a = $signed({16'd0, e_q}); mul_b = cov_bb; end
      OP_EC:   begin mul_a = $signed({16'd0, e_q}); mul_b = acc;    end
      OP_ET:   begin mul_a = $signed({16'd0, e_q}); mul_b = t_q;    end
      OP_M0:   begin mul_a = k0; mul_b = y;      end
      OP_M1:   begin mul_a = k1; mul_b = y;      end
      OP_M2:   begin mul_a = k0; mul_b = cov_aa; end
      OP_M3:   begin mul_a = k0; mul_b = cov_ab; end
      OP_M4:   begin mul_a = k1; mul_b = cov_aa; end
      OP_M5:   begin mul_a = k1; mul_b = cov_ab; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  // Integer products saturate directly; fixed-point ones shift with floor.
  always_comb begin
    case (cmd.op)
      OP_ANG, OP_T, OP_EC, OP_ET: mul_r = clamp64(prod);
      default:                    mul_r = clamp64(prod >>> FRAC_BITS);
    endcase
  end

  gakf_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.op == OP_DIVSTART),
    .num  (cmd.div_sel ? cov_ba : cov_aa),
    .den  (ps),
    .done (div_done),
    .quo  (div_q)
  );

  assign sts.div_done = div_done;
  assign sts.s_zero   = (ps == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_reg <= '0;
      bias_reg  <= '0;
      cov_aa <= '0;
      cov_ab <= '0;
      cov_ba <= '0;
      cov_bb <= '0;
    end else begin
      case (cmd.op)
        OP_ANG: angle_reg <= sadd(angle_reg, mul_r);
        OP_PRED: begin
          cov_aa <= sadd(p00, $signed({1'b0, angle_noise}));
          cov_ab <= ssub(cov_ab, t_q);
          cov_ba <= ssub(cov_ba, t_q);
          cov_bb <= sadd(cov_bb, $signed({1'b0, bias_noise}));
        end
        OP_M0: angle_reg <= sadd(angle_reg, mul_r);
        OP_M1: bias_reg  <= sadd(bias_reg, mul_r);
        OP_COMMIT: begin
          cov_aa <= na_aa;
          cov_ab <= na_ab;
          cov_ba <= na_ba;
          cov_bb <= na_bb;
        end
        default: ;
      endcase
    end
  end

  // Scratch registers have no reset; ps also feeds control through the s_zero status.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        rate_q <= rate_sample;
        meas_q <= angle_sample;
        e_q    <= elapsed;
      end
      OP_RB:   acc <= ssub(rate_q, bias_reg);
      OP_T:    t_q <= mul_r;
      OP_SUMC: acc <= sadd(cov_ba, cov_ab);
      OP_EC:   acc <= mul_r;
      OP_P00A: p00 <= ssub(cov_aa, acc);
      OP_ET:   acc <= mul_r;
      OP_P00B: p00 <= sadd(p00, acc);
      OP_S:    begin
        ps <= sadd(cov_aa, $signed({1'b0, measure_noise}));
        y  <= ssub(meas_q, angle_reg);
      end
      OP_K0:   k0 <= div_q;
      OP_K1:   k1 <= div_q;
      OP_M2:   na_aa <= ssub(cov_aa, mul_r);
      OP_M3:   na_ab <= ssub(cov_ab, mul_r);
      OP_M4:   na_ba <= ssub(cov_ba, mul_r);
      OP_M5:   na_bb <= ssub(cov_bb, mul_r);
      default: ;
    endcase
  end

  assign angle_estimate = angle_reg;
  assign bias_estimate  = bias_reg;

endmodule

[src/gakf_control.sv]
// Sequencer: walks the predict and update steps, waits on the divider.
module gakf_control import gakf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output logic    fault,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PRED  = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_UPD   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;
  op_t    step, step_next;
  logic   div_sel, div_sel_next;
  logic   accept;

  assign in_stall = rst || (state != ST_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next   = state;
    step_next    = step;
    div_sel_next = div_sel;
    cmd.op       = OP_NONE;
    cmd.div_sel  = div_sel;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.op = OP_LOAD;
          state_next = ST_PRED;
          step_next = OP_RB;
          div_sel_next = 1'b0;
        end
      end
      ST_PRED: begin
        cmd.op = step;
        if (step == OP_S) begin
          state_next = ST_CHECK;
        end else begin
          step_next = op_t'(step + 1'b1);
        end
      end
      ST_CHECK: begin
        if (sts.s_zero) begin
          state_next = ST_DONE;
        end else begin
          cmd.op = OP_DIVSTART;
          div_sel_next = 1'b0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.op = div_sel ? OP_K1 : OP_K0;
          if (!div_sel) begin
            state_next = ST_CHECK;
            div_sel_next = 1'b1;
          end else begin
            state_next = ST_UPD;
            step_next = OP_M0;
          end
        end
      end
      ST_UPD: begin
        cmd.op = step;
        if (step == OP_COMMIT) begin
          state_next = ST_DONE;
        end else begin
          step_next = op_t'(step + 1'b1);
        end
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
    // Second divide reuses the check state to start with the other numerator.
    if (state == ST_CHECK && div_sel && !sts.s_zero) begin
      cmd.div_sel = 1'b1;
      div_sel_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= OP_NONE;
      div_sel <= 1'b0;
      out_valid <= 1'b0;
      fault <= 1'b0;
    end else begin
      state <= state_next;
      step <= step_next;
      div_sel <= div_sel_next;
      if (state == ST_DONE) begin
        out_valid <= 1'b1;
        fault <= sts.s_zero;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A result is presented only when the sequence has finished.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside done state");
  assert property (@(posedge clk) disable iff (rst)
    accept |-> state == ST_IDLE)
    else $error("sample taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> state == ST_DIV)
    else $error("divider finished while not awaited");

endmodule

[src/gyro_angle_kalman_filter_core.sv]
// The result waits on the two gain divisions, done one after the other through the
// one bit-per-cycle divider. One sample is processed at a time; the next sample is
// taken in the cycle the result leaves. A zero innovation variance skips the
// divisions and the update steps.
// Reset (rst, synchronous): state and covariance clear, noise registers load defaults.
module gyro_angle_kalman_filter_core import gakf_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] rate_sample,
  input  logic signed [31:0] angle_sample,
  input  logic [15:0]        elapsed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] angle_estimate,
  output logic signed [31:0] bias_estimate,
  output logic               divide_fault,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [30:0] angle_noise, bias_noise, measure_noise;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_noise   <= AngleNoiseReset;
      bias_noise    <= BiasNoiseReset;
      measure_noise <= MeasureNoiseReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegAngleNoise:   angle_noise   <= cfg_data[30:0];
        RegBiasNoise:    bias_noise    <= cfg_data[30:0];
        RegMeasureNoise: measure_noise <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  gakf_control u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .fault    (divide_fault),
    .cmd      (cmd),
    .sts      (sts)
  );

  gakf_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .rate_sample   (rate_sample),
    .angle_sample  (angle_sample),
    .elapsed       (elapsed),
    .angle_noise   (angle_noise),
    .bias_noise    (bias_noise),
    .measure_noise (measure_noise),
    .angle_estimate(angle_estimate),
    .bias_estimate (bias_estimate)
  );

endmodule
